// ===== rtl/core/sspcr_pkg.sv =====
// Shared types, codes and defaults for the stream switch packet/circuit router.
// Used by every module in rtl/core; depends on nothing.
package sspcr_pkg;

  localparam int NumSlaves    = 32;
  localparam int NumMasters   = 32;
  localparam int SlotsPerPort = 4;

  typedef enum logic [1:0] {
    OP_BEAT   = 2'd0,
    OP_MASTER = 2'd1,
    OP_SLAVE  = 2'd2,
    OP_SLOT   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_FWD         = 3'd0,
    ST_NO_LISTENER = 3'd1,
    ST_FULL        = 3'd2,
    ST_HDR_DROP    = 3'd3,
    ST_SLAVE_OFF   = 3'd4,
    ST_WRITTEN     = 3'd5
  } status_t;

  typedef struct packed {
    op_t         op;
    logic [4:0]  port;
    logic [4:0]  mst;
    logic [1:0]  slot;
    logic [31:0] val;
    logic [31:0] word;
    logic        last;
    logic [31:0] full;
    logic        port_ok;
    logic        mst_ok;
    logic        slot_ok;
  } item_t;

  typedef struct packed {
    logic       en;
    logic       pkt;
    logic       drop;
    logic [6:0] cfg;
  } master_ent_t;

  typedef struct packed {
    logic       en;
    logic [4:0] id;
    logic [4:0] mask;
    logic [1:0] msel;
    logic [2:0] arb;
  } slot_rule_t;

  typedef struct packed {
    logic       in_pkt;
    logic [2:0] arb;
    logic [1:0] msel;
  } track_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] mask;
    logic [31:0] word;
    logic        last;
    logic        hdr;
    logic [2:0]  arb;
    logic [1:0]  msel;
  } result_t;

  function automatic slot_rule_t unpack_rule(input logic [31:0] v);
    slot_rule_t r;
    r.en   = v[8];
    r.id   = v[28:24];
    r.mask = v[20:16];
    r.msel = v[5:4];
    r.arb  = v[2:0];
    return r;
  endfunction

endpackage

// ===== rtl/core/sspcr_front.sv =====
// Front end: takes input beats, unpacks them and checks index ranges.
// Depends on sspcr_pkg.
module sspcr_front #(
  parameter int NUM_SLAVES     = sspcr_pkg::NumSlaves,
  parameter int NUM_MASTERS    = sspcr_pkg::NumMasters,
  parameter int SLOTS_PER_PORT = sspcr_pkg::SlotsPerPort
) (
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [111:0]       s_tdata,
  input  logic [1:0]         s_tuser,
  input  logic               s_tlast,
  input  logic               q_ready,
  output logic               q_push,
  output sspcr_pkg::item_t   q_item
);

  assign s_tready = q_ready;
  assign q_push   = s_tvalid && q_ready;

  always_comb begin
    q_item.op      = sspcr_pkg::op_t'(s_tuser);
    q_item.port    = s_tdata[4:0];
    q_item.mst     = s_tdata[9:5];
    q_item.slot    = s_tdata[11:10];
    q_item.val     = s_tdata[43:12];
    q_item.word    = s_tdata[75:44];
    q_item.last    = s_tlast;
    q_item.full    = s_tdata[107:76];
    q_item.port_ok = 32'(s_tdata[4:0]) < NUM_SLAVES;
    q_item.mst_ok  = 32'(s_tdata[9:5]) < NUM_MASTERS;
    q_item.slot_ok = 32'(s_tdata[11:10]) < SLOTS_PER_PORT;
  end

endmodule

// ===== rtl/core/sspcr_fifo.sv =====
// Two-entry queue between the front end and the execution back end.
// Depends on sspcr_pkg.
module sspcr_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sspcr_pkg::item_t push_item,
  output logic             ready,
  input  logic             pop,
  output logic             valid,
  output sspcr_pkg::item_t head
);

  sspcr_pkg::item_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign ready = count != 2'd2;
  assign valid = count != 2'd0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== rtl/core/sspcr_back.sv =====
// Back end: routing tables, slot rule memory, beat routing and the result register.
// Depends on sspcr_pkg.
module sspcr_back #(
  parameter int NUM_SLAVES     = sspcr_pkg::NumSlaves,
  parameter int NUM_MASTERS    = sspcr_pkg::NumMasters,
  parameter int SLOTS_PER_PORT = sspcr_pkg::SlotsPerPort
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  sspcr_pkg::item_t    q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output sspcr_pkg::result_t  out_res
);

  localparam int MEFF = (NUM_MASTERS < 32) ? NUM_MASTERS : 32;
  localparam int SIW  = (NUM_SLAVES > 1) ? $clog2(NUM_SLAVES) : 1;
  localparam int MIW  = (MEFF > 1) ? $clog2(MEFF) : 1;

  sspcr_pkg::master_ent_t master_tbl [MEFF];
  logic [1:0]             slave_tbl  [NUM_SLAVES];
  sspcr_pkg::track_t      track      [NUM_SLAVES];
  sspcr_pkg::slot_rule_t  rule_mem   [NUM_SLAVES][SLOTS_PER_PORT];
  logic [NUM_SLAVES-1:0]  row_valid;

  logic                   ex_valid;
  sspcr_pkg::item_t       ex;
  sspcr_pkg::slot_rule_t  rd_row [SLOTS_PER_PORT];
  logic                   rd_vld;

  // A slot write that lands on the row being read in the same cycle is patched in afterwards.
  logic                      byp_valid;
  logic [SLOTS_PER_PORT-1:0] byp_lanes;
  sspcr_pkg::slot_rule_t     byp_row [SLOTS_PER_PORT];

  logic                      ex_adv;
  logic                      load;
  logic [SIW-1:0]            q_idx;
  logic [SIW-1:0]            ex_idx;
  logic [MIW-1:0]            m_idx;
  logic                      mem_we;
  logic [SLOTS_PER_PORT-1:0] wr_lanes;
  sspcr_pkg::slot_rule_t     wr_row [SLOTS_PER_PORT];
  sspcr_pkg::slot_rule_t     eff_row [SLOTS_PER_PORT];
  sspcr_pkg::result_t        res_next;
  logic                      trk_we;
  sspcr_pkg::track_t         trk_next;

  assign ex_adv = ex_valid && (!out_valid || out_ready);
  assign load   = q_valid && (!ex_valid || ex_adv);
  assign q_pop  = load;
  assign q_idx  = SIW'(q_item.port);
  assign ex_idx = SIW'(ex.port);
  assign m_idx  = MIW'(ex.mst);
  assign mem_we = ex_adv && ex.op == sspcr_pkg::OP_SLOT && ex.port_ok && ex.slot_ok;

  always_comb begin
    for (int l = 0; l < SLOTS_PER_PORT; l++) begin
      wr_lanes[l] = !row_valid[ex_idx] || 32'(ex.slot) == l;
      wr_row[l]   = (32'(ex.slot) == l) ? sspcr_pkg::unpack_rule(ex.val) : '0;
      eff_row[l]  = rd_vld ? rd_row[l] : '0;
      if (byp_valid && byp_lanes[l]) begin
        eff_row[l] = byp_row[l];
      end
    end
  end

  // The patch is captured with the beat and held for as long as the beat waits in execute.
  always_ff @(posedge clk) begin
    if (load) begin
      ex        <= q_item;
      rd_row    <= rule_mem[q_idx];
      rd_vld    <= row_valid[q_idx];
      byp_lanes <= wr_lanes;
      byp_row   <= wr_row;
    end
    if (mem_we) begin
      for (int l = 0; l < SLOTS_PER_PORT; l++) begin
        if (wr_lanes[l]) begin
          rule_mem[ex_idx][l] <= wr_row[l];
        end
      end
    end
  end

  // Routing of the beat held in the execute register.
  always_comb begin
    logic [MEFF-1:0]     cand;
    logic [MEFF-1:0]     free;
    logic [MEFF-1:0]     listen;
    logic [MEFF-1:0]     dests;
    logic [MEFF-1:0]     drops;
    logic [MEFF-1:0]     full_m;
    logic                hdr;
    logic                hit;
    logic [2:0]          arb;
    logic [1:0]          msel;
    logic [2:0]          h_arb;
    logic [1:0]          h_msel;
    logic [3:0]          sel;
    sspcr_pkg::track_t   trk;

    res_next = '0;
    trk_we   = 1'b0;
    trk_next = '0;
    trk      = track[ex_idx];
    hdr      = !trk.in_pkt;
    full_m   = MEFF'(ex.full);
    hit      = 1'b0;
    h_arb    = '0;
    h_msel   = '0;
    for (int s = SLOTS_PER_PORT - 1; s >= 0; s--) begin
      if (eff_row[s].en && (ex.word[4:0] & eff_row[s].mask) == eff_row[s].id) begin
        hit    = 1'b1;
        h_arb  = eff_row[s].arb;
        h_msel = eff_row[s].msel;
      end
    end
    arb  = hdr ? h_arb : trk.arb;
    msel = hdr ? h_msel : trk.msel;
    for (int m = 0; m < MEFF; m++) begin
      sel       = master_tbl[m].cfg[6:3];
      cand[m]   = master_tbl[m].en && !master_tbl[m].pkt
                  && master_tbl[m].cfg == {2'b00, ex.port};
      listen[m] = master_tbl[m].en && master_tbl[m].pkt
                  && master_tbl[m].cfg[2:0] == arb && sel[msel];
      drops[m]  = master_tbl[m].drop;
    end
    free  = cand & ~full_m;
    dests = listen & ~(hdr ? drops : '0);

    if (ex.op != sspcr_pkg::OP_BEAT) begin
      res_next.status = sspcr_pkg::ST_WRITTEN;
    end else if (!ex.port_ok || !slave_tbl[ex_idx][1]) begin
      res_next.status = sspcr_pkg::ST_SLAVE_OFF;
    end else if (!slave_tbl[ex_idx][0]) begin
      if (free != '0) begin
        res_next.status = sspcr_pkg::ST_FWD;
        res_next.mask   = 32'(free & (~free + 1'b1));
        res_next.word   = ex.word;
        res_next.last   = ex.last;
      end else if (cand != '0) begin
        res_next.status = sspcr_pkg::ST_FULL;
      end else begin
        res_next.status = sspcr_pkg::ST_NO_LISTENER;
      end
    end else if (hdr && !hit) begin
      res_next.status = sspcr_pkg::ST_HDR_DROP;
      res_next.hdr    = 1'b1;
    end else begin
      res_next.hdr  = hdr;
      res_next.arb  = arb;
      res_next.msel = msel;
      if (listen == '0) begin
        res_next.status = sspcr_pkg::ST_NO_LISTENER;
      end else if ((dests & full_m) != '0) begin
        res_next.status = sspcr_pkg::ST_FULL;
      end else begin
        res_next.status = sspcr_pkg::ST_FWD;
        res_next.mask   = 32'(dests);
        res_next.word   = ex.word;
        res_next.last   = ex.last;
        trk_we          = 1'b1;
        trk_next        = '{in_pkt: !ex.last, arb: arb, msel: msel};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid  <= 1'b0;
      out_valid <= 1'b0;
      byp_valid <= 1'b0;
      row_valid <= '0;
      for (int m = 0; m < MEFF; m++) begin
        master_tbl[m] <= '0;
      end
      for (int p = 0; p < NUM_SLAVES; p++) begin
        slave_tbl[p] <= '0;
        track[p]     <= '0;
      end
    end else begin
      if (load) begin
        byp_valid <= mem_we && q_idx == ex_idx;
      end
      if (load) begin
        ex_valid <= 1'b1;
      end else if (ex_adv) begin
        ex_valid <= 1'b0;
      end
      if (ex_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (ex_adv) begin
        if (ex.op == sspcr_pkg::OP_MASTER && ex.mst_ok) begin
          master_tbl[m_idx] <= '{en: ex.val[31], pkt: ex.val[30], drop: ex.val[7],
                                 cfg: ex.val[6:0]};
        end
        if (ex.op == sspcr_pkg::OP_SLAVE && ex.port_ok) begin
          slave_tbl[ex_idx] <= ex.val[31:30];
          track[ex_idx]     <= '0;
        end
        if (mem_we) begin
          row_valid[ex_idx] <= 1'b1;
        end
        if (ex.op == sspcr_pkg::OP_BEAT && trk_we) begin
          track[ex_idx] <= trk_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ex_adv) begin
      out_res <= res_next;
    end
  end

`ifndef SYNTHESIS
  a_mask_only_fwd: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.status != sspcr_pkg::ST_FWD |-> out_res.mask == '0 && out_res.word == '0)
    else $error("mask or word set on a beat that was not forwarded");
  a_written_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.status == sspcr_pkg::ST_WRITTEN |-> !out_res.hdr && out_res.arb == '0)
    else $error("register write reported routing information");
  a_no_load_when_stuck: assert property (@(posedge clk) disable iff (rst)
    ex_valid && out_valid && !out_ready |-> !load)
    else $error("execute register overwritten while stalled");
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !ex_valid)
    else $error("pipeline not empty after reset");
`endif

endmodule

// ===== rtl/core/stream_switch_packet_circuit_router.sv =====
// Stream switch router, packet and circuit modes. Results are registered; one item per cycle
// is sustained unless the output stalls, limited by the single execute stage that reads and
// updates the routing tables. The slot rule memory read is registered, with a bypass for a
// write to the same row. Reset (synchronous) disables every master, slave and slot rule and
// clears all packets in flight at once; there is no clearing pass.
module stream_switch_packet_circuit_router #(
  parameter int NUM_SLAVES     = sspcr_pkg::NumSlaves,
  parameter int NUM_MASTERS    = sspcr_pkg::NumMasters,
  parameter int SLOTS_PER_PORT = sspcr_pkg::SlotsPerPort
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // port[4:0], master[9:5], slot[11:10], reg_value[43:12], beat_word[75:44],
  // master_full[107:76], zero [111:108]
  input  logic [111:0] s_tdata,
  // op[1:0]
  input  logic [1:0]   s_tuser,
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // deliver_mask[31:0], out_word[63:32], route_arbiter[66:64], route_msel[68:67], zero [71:69]
  output logic [71:0]  m_tdata,
  // status[2:0], was_header[3]
  output logic [3:0]   m_tuser,
  output logic         m_tlast
);

  sspcr_pkg::item_t   push_item;
  sspcr_pkg::item_t   head;
  sspcr_pkg::result_t res;
  logic               q_ready;
  logic               push;
  logic               pop;
  logic               q_valid;

  sspcr_front #(
    .NUM_SLAVES(NUM_SLAVES), .NUM_MASTERS(NUM_MASTERS), .SLOTS_PER_PORT(SLOTS_PER_PORT)
  ) u_front (
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .s_tlast(s_tlast), .q_ready(q_ready), .q_push(push), .q_item(push_item)
  );

  sspcr_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .push_item(push_item), .ready(q_ready),
    .pop(pop), .valid(q_valid), .head(head)
  );

  sspcr_back #(
    .NUM_SLAVES(NUM_SLAVES), .NUM_MASTERS(NUM_MASTERS), .SLOTS_PER_PORT(SLOTS_PER_PORT)
  ) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_item(head), .q_pop(pop),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
  );

  assign m_tdata = {3'b000, res.msel, res.arb, res.word, res.mask};
  assign m_tuser = {res.hdr, res.status};
  assign m_tlast = res.last;

endmodule
